// ----- rtl/qrs_pkg.sv -----
// shared types, constants and helpers for the quadratic root solver
// no dependencies; used by qrs_div_pipe and quadratic_root_solver_core
package qrs_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int ROOT_W        = 64;
    localparam int TOL_W         = 16;
    localparam int QFRAC         = 32;   // fraction bits of a root
    localparam int SQRT_BITS     = 34;   // bits of the integer square root
    localparam int DISC_W        = 66;   // discriminant magnitude width
    localparam int DIV_NUM_W     = 34;   // divider operand width
    localparam int DIV_Q_W       = DIV_NUM_W + QFRAC;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_quad;
        logic signed [COEF_W-1:0] coef_lin;
        logic signed [COEF_W-1:0] coef_const;
    } t_qrs_in;

    typedef struct packed {
        logic [1:0]               root_count;
        logic signed [ROOT_W-1:0] root_first;
        logic signed [ROOT_W-1:0] root_second;
        logic                     overflow;
    } t_qrs_out;

    // coefficient data carried along the front of the pipeline
    typedef struct packed {
        logic              an;
        logic              bn;
        logic              cn;
        logic [COEF_W-1:0] am;
        logic [COEF_W-1:0] bm;
        logic [COEF_W-1:0] cm;
        logic [TOL_W-1:0]  tol;
        logic              a_z;
        logic              b_z;
        logic              c_z;
        logic              d_z;
        logic              dneg;
    } t_qrs_side;

    // per-item control carried beside the dividers
    typedef struct packed {
        logic [1:0] count;
        logic       neg1;
        logic       neg2;
        logic       use1;
        logic       use2;
    } t_qrs_ctl;

    // sign and magnitude of a two's complement coefficient
    function automatic logic [COEF_W:0] split(input logic [COEF_W-1:0] raw);
        logic [COEF_W-1:0] mag;
        mag = raw[COEF_W-1] ? (~raw + COEF_W'(1)) : raw;
        return {raw[COEF_W-1], mag};
    endfunction

    // saturate an unsigned quotient to signed Q32.32, msb of result is overflow
    function automatic logic [ROOT_W:0] saturate(input logic neg,
                                                 input logic [DIV_Q_W-1:0] q);
        logic             ovf;
        logic [ROOT_W-1:0] v;
        if (neg) begin
            ovf = q > DIV_Q_W'({1'b1, {(ROOT_W-1){1'b0}}});
            v   = ovf ? {1'b1, {(ROOT_W-1){1'b0}}} : (~q[ROOT_W-1:0] + ROOT_W'(1));
        end else begin
            ovf = q > DIV_Q_W'({1'b0, {(ROOT_W-1){1'b1}}});
            v   = ovf ? {1'b0, {(ROOT_W-1){1'b1}}} : q[ROOT_W-1:0];
        end
        return {ovf, v};
    endfunction

endpackage

// ----- rtl/qrs_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage
// computes (num << QFRAC) / den; uses qrs_pkg
module qrs_div_pipe #(
    parameter int NUM_W = qrs_pkg::DIV_NUM_W
) (
    input  logic                           i_clk,
    input  logic [NUM_W-1:0]               i_num,
    input  logic [NUM_W-1:0]               i_den,
    output logic [NUM_W+qrs_pkg::QFRAC-1:0] o_quot
);
    localparam int Q_W = NUM_W + qrs_pkg::QFRAC;

    logic [NUM_W-1:0] r_rem [0:Q_W];
    logic [Q_W-1:0]   r_dvd [0:Q_W];
    logic [NUM_W-1:0] r_den [0:Q_W];
    logic [Q_W-1:0]   r_quo [0:Q_W];

    assign r_rem[0] = '0;
    assign r_dvd[0] = {i_num, {qrs_pkg::QFRAC{1'b0}}};
    assign r_den[0] = i_den;
    assign r_quo[0] = '0;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [NUM_W:0]   trial;
        logic             fits;
        logic [NUM_W-1:0] n_rem;
        always_comb begin
            trial = {r_rem[k], r_dvd[k][Q_W-1]};
            fits  = trial >= {1'b0, r_den[k]};
            n_rem = fits ? NUM_W'(trial - {1'b0, r_den[k]}) : trial[NUM_W-1:0];
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_rem;
            r_dvd[k+1] <= {r_dvd[k][Q_W-2:0], 1'b0};
            r_den[k+1] <= r_den[k];
            r_quo[k+1] <= {r_quo[k][Q_W-2:0], fits};
        end
    end

    assign o_quot = r_quo[Q_W];

endmodule

// ----- rtl/quadratic_root_solver_core.sv -----
// top level of the quadratic root solver: split, multiply, discriminant,
// square root, case decision, two dividers, saturation; uses qrs_pkg, qrs_div_pipe
//
// Solves a*x^2 + b*x + c = 0 for signed Q16.16 coefficients and returns the
// root count and two roots in signed Q32.32. The block is a fixed pipeline
// with no stalls: busy is always low, a new word may be started in every
// cycle, and each result appears on o_roots with o_strobe high for exactly
// one cycle, after 3 front stages, 34 square-root stages, one decision
// stage, 66 divider stages and one output stage. The latency is set by the
// one-bit-per-stage square root and dividers. Results come out in start
// order. The user must write zero_tolerance through i_cfg_we and i_cfg_wdata
// only while no words are in flight; the block does not enforce this.
module quadratic_root_solver_core #(
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  qrs_pkg::t_qrs_in                  i_coefs,
    output logic                              o_strobe,
    output qrs_pkg::t_qrs_out                 o_roots,
    input  logic                              i_cfg_we,
    input  logic [qrs_pkg::TOL_W-1:0]         i_cfg_wdata
);
    localparam int SQ_BITS = qrs_pkg::SQRT_BITS;
    localparam int D_W     = qrs_pkg::DISC_W;
    localparam int SQ_W    = 2 * SQ_BITS;
    localparam int NUM_W   = qrs_pkg::DIV_NUM_W;
    localparam int Q_W     = qrs_pkg::DIV_Q_W;
    localparam int C_W     = qrs_pkg::COEF_W;
    localparam int LATENCY = 3 + SQ_BITS + 1 + Q_W + 1;

    // no backpressure anywhere: a word can enter every cycle
    assign busy = 1'b0;

    // zero tolerance register
    logic [qrs_pkg::TOL_W-1:0] r_tol;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= qrs_pkg::TOL_W'(1);
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // stage 1: sign/magnitude split and small zero tests
    logic               r_s1_valid;
    qrs_pkg::t_qrs_side r_s1_side;
    qrs_pkg::t_qrs_side n_s1_side;
    logic [C_W:0]       sa, sb, sc;

    always_comb begin
        sa = qrs_pkg::split(i_coefs.coef_quad);
        sb = qrs_pkg::split(i_coefs.coef_lin);
        sc = qrs_pkg::split(i_coefs.coef_const);
        n_s1_side      = '0;
        n_s1_side.an   = sa[C_W];
        n_s1_side.bn   = sb[C_W];
        n_s1_side.cn   = sc[C_W];
        n_s1_side.am   = sa[C_W-1:0];
        n_s1_side.bm   = sb[C_W-1:0];
        n_s1_side.cm   = sc[C_W-1:0];
        n_s1_side.tol  = r_tol;
        n_s1_side.a_z  = sa[C_W-1:0] <= C_W'(r_tol);
        n_s1_side.b_z  = sb[C_W-1:0] <= C_W'(r_tol);
        n_s1_side.c_z  = sc[C_W-1:0] <= C_W'(r_tol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
    end
    always_ff @(posedge i_clk) begin
        r_s1_side <= n_s1_side;
    end

    // stage 2: b*b and a*c on magnitudes
    logic               r_s2_valid;
    qrs_pkg::t_qrs_side r_s2_side;
    logic [2*C_W-1:0]   r_s2_bsq, r_s2_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        r_s2_side <= r_s1_side;
        r_s2_bsq  <= (2*C_W)'(r_s1_side.bm) * (2*C_W)'(r_s1_side.bm);
        r_s2_ac   <= (2*C_W)'(r_s1_side.am) * (2*C_W)'(r_s1_side.cm);
    end

    // stage 3: discriminant sign/magnitude, feeds square root stage 0
    logic               r_sq_valid [0:SQ_BITS];
    qrs_pkg::t_qrs_side r_sq_side  [0:SQ_BITS];
    logic [D_W-1:0]     r_sq_d     [0:SQ_BITS];
    logic [SQ_BITS-1:0] r_sq_root  [0:SQ_BITS];
    logic [SQ_W-1:0]    r_sq_acc   [0:SQ_BITS];

    logic [D_W-1:0]     ac4, bsq_x, n_dmag, dtol;
    logic               n_dneg;
    qrs_pkg::t_qrs_side n_s3_side;

    always_comb begin
        ac4    = {r_s2_ac, 2'b00};
        bsq_x  = D_W'(r_s2_bsq);
        n_dneg = 1'b0;
        if (r_s2_side.an != r_s2_side.cn) begin
            n_dmag = bsq_x + ac4;
        end else if (bsq_x >= ac4) begin
            n_dmag = bsq_x - ac4;
        end else begin
            n_dmag = ac4 - bsq_x;
            n_dneg = 1'b1;
        end
        dtol           = D_W'(r_s2_side.tol) << FRAC_BITS;
        n_s3_side      = r_s2_side;
        n_s3_side.dneg = n_dneg;
        n_s3_side.d_z  = n_dmag <= dtol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else begin
            r_sq_valid[0] <= r_s2_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        r_sq_side[0] <= n_s3_side;
        r_sq_d[0]    <= n_dmag;
        r_sq_root[0] <= '0;
        r_sq_acc[0]  <= '0;
    end

    // square root: one root bit per stage, acc tracks root squared
    for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
        localparam int BIT = SQ_BITS - 1 - k;
        logic [SQ_W-1:0] t_sq;
        logic            take;
        always_comb begin
            t_sq = r_sq_acc[k] + (SQ_W'(r_sq_root[k]) << (BIT + 1))
                 + (SQ_W'(1) << (2 * BIT));
            take = t_sq <= SQ_W'(r_sq_d[k]);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k+1] <= 1'b0;
            end else begin
                r_sq_valid[k+1] <= r_sq_valid[k];
            end
        end
        always_ff @(posedge i_clk) begin
            r_sq_side[k+1] <= r_sq_side[k];
            r_sq_d[k+1]    <= r_sq_d[k];
            r_sq_root[k+1] <= take ? (r_sq_root[k] | (SQ_BITS'(1) << BIT)) : r_sq_root[k];
            r_sq_acc[k+1]  <= take ? t_sq : r_sq_acc[k];
        end
    end

    // decision: pick the case and the operands of both dividers
    qrs_pkg::t_qrs_side sd;
    logic signed [35:0] bval, sum;
    logic [35:0]        sm, tol2;
    logic               sum_pos;
    qrs_pkg::t_qrs_ctl  n_ctl;
    logic [NUM_W-1:0]   n_num1, n_den1, n_num2, n_den2;

    always_comb begin
        sd      = r_sq_side[SQ_BITS];
        bval    = sd.bn ? -$signed({4'b0, sd.bm}) : $signed({4'b0, sd.bm});
        sum     = bval + $signed({2'b0, r_sq_root[SQ_BITS]});
        sm      = sum[35] ? 36'(-sum) : 36'(sum);
        sum_pos = !sum[35] && (sum != '0);
        tol2    = {19'b0, sd.tol, 1'b0};
        n_ctl   = '0;
        n_num1  = '0;
        n_den1  = NUM_W'(1);
        n_num2  = '0;
        n_den2  = NUM_W'(1);
        if (sd.a_z) begin
            // linear equation
            if (sd.b_z) begin
                n_ctl.count = sd.c_z ? qrs_pkg::CNT_INF : qrs_pkg::CNT_NONE;
            end else begin
                n_ctl.count = qrs_pkg::CNT_ONE;
                n_ctl.use1  = 1'b1;
                n_ctl.neg1  = !sd.cn ^ sd.bn;
                n_num1      = NUM_W'(sd.cm);
                n_den1      = NUM_W'(sd.bm);
            end
        end else if (sd.d_z) begin
            // double root -b/(2a)
            n_ctl.count = qrs_pkg::CNT_ONE;
            n_ctl.use1  = 1'b1;
            n_ctl.neg1  = !sd.bn ^ sd.an;
            n_num1      = NUM_W'(sd.bm);
            n_den1      = NUM_W'({sd.am, 1'b0});
        end else if (!sd.dneg) begin
            n_ctl.count = qrs_pkg::CNT_TWO;
            n_ctl.use1  = 1'b1;
            if (sm <= tol2) begin
                // temp near zero: x1 = -b/a, x2 = 0
                n_ctl.neg1 = !sd.bn ^ sd.an;
                n_num1     = NUM_W'(sd.bm);
                n_den1     = NUM_W'(sd.am);
            end else begin
                n_ctl.use2 = 1'b1;
                n_ctl.neg1 = sum_pos ^ sd.an;
                n_num1     = sm[NUM_W-1:0];
                n_den1     = NUM_W'({sd.am, 1'b0});
                n_ctl.neg2 = !sd.cn ^ sum[35];
                n_num2     = NUM_W'({sd.cm, 1'b0});
                n_den2     = sm[NUM_W-1:0];
            end
        end else begin
            n_ctl.count = qrs_pkg::CNT_NONE;
        end
    end

    logic               r_dl_valid [0:Q_W];
    qrs_pkg::t_qrs_ctl  r_dl_ctl   [0:Q_W];
    logic [NUM_W-1:0]   r_dc_num1, r_dc_den1, r_dc_num2, r_dc_den2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_valid[0] <= 1'b0;
        end else begin
            r_dl_valid[0] <= r_sq_valid[SQ_BITS];
        end
    end
    always_ff @(posedge i_clk) begin
        r_dl_ctl[0] <= n_ctl;
        r_dc_num1   <= n_num1;
        r_dc_den1   <= n_den1;
        r_dc_num2   <= n_num2;
        r_dc_den2   <= n_den2;
    end

    // control delay line matching the divider latency
    for (genvar k = 0; k < Q_W; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dl_valid[k+1] <= 1'b0;
            end else begin
                r_dl_valid[k+1] <= r_dl_valid[k];
            end
        end
        always_ff @(posedge i_clk) begin
            r_dl_ctl[k+1] <= r_dl_ctl[k];
        end
    end

    logic [Q_W-1:0] quot1, quot2;

    qrs_div_pipe #(.NUM_W(NUM_W)) u_div1 (
        .i_clk  (i_clk),
        .i_num  (r_dc_num1),
        .i_den  (r_dc_den1),
        .o_quot (quot1)
    );

    qrs_div_pipe #(.NUM_W(NUM_W)) u_div2 (
        .i_clk  (i_clk),
        .i_num  (r_dc_num2),
        .i_den  (r_dc_den2),
        .o_quot (quot2)
    );

    // output stage: saturate, zero unused roots, register the word
    qrs_pkg::t_qrs_ctl oc;
    logic [qrs_pkg::ROOT_W:0] sat1, sat2;
    qrs_pkg::t_qrs_out n_out;
    qrs_pkg::t_qrs_out r_out;
    logic              r_strobe;

    always_comb begin
        oc   = r_dl_ctl[Q_W];
        sat1 = qrs_pkg::saturate(oc.neg1, quot1);
        sat2 = qrs_pkg::saturate(oc.neg2, quot2);
        n_out.root_count  = oc.count;
        n_out.root_first  = oc.use1 ? sat1[qrs_pkg::ROOT_W-1:0] : '0;
        n_out.root_second = oc.use2 ? sat2[qrs_pkg::ROOT_W-1:0] : '0;
        n_out.overflow    = (oc.use1 && sat1[qrs_pkg::ROOT_W])
                         || (oc.use2 && sat2[qrs_pkg::ROOT_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_dl_valid[Q_W];
        end
    end
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_roots  = r_out;

    // every started word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_strobe)
        else $error("started word did not come out on time");

    // no roots or infinitely many roots carry zero fields and no overflow
    a_no_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_roots.root_count == qrs_pkg::CNT_NONE
                   || o_roots.root_count == qrs_pkg::CNT_INF))
        |-> (o_roots.root_first == '0 && o_roots.root_second == '0
             && !o_roots.overflow))
        else $error("root fields set without a root");

    // a single root leaves the second field zero
    a_one_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_roots.root_count == qrs_pkg::CNT_ONE)
        |-> (o_roots.root_second == '0))
        else $error("second root set for a single root");

    // a second divider result is used only for two roots
    a_use2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dl_valid[Q_W] && r_dl_ctl[Q_W].use2)
        |-> (r_dl_ctl[Q_W].count == qrs_pkg::CNT_TWO && r_dl_ctl[Q_W].use1))
        else $error("second divider used outside the two-root case");

endmodule
